>>> hdl/dds_step_pulse_generator_macros.svh
// assertion macros for the step pulse generator
`ifndef DDS_STEP_PULSE_GENERATOR_MACROS_SVH
`define DDS_STEP_PULSE_GENERATOR_MACROS_SVH

`ifndef SYNTH

// consequent checked in the clock after the antecedent
`define DSPG_ASSERT_NEXT(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dspg next-cycle check failed");

// consequent checked in the same clock as the antecedent
`define DSPG_ASSERT_SAME(label, clock, rstn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dspg same-cycle check failed");

`else

`define DSPG_ASSERT_NEXT(label, clock, rstn, ante, cons)
`define DSPG_ASSERT_SAME(label, clock, rstn, ante, cons)

`endif

`endif

>>> hdl/dspg_pkg.sv
`timescale 1ns / 1ps

package dspg_pkg;

    localparam int VEL_BITS  = 16;
    localparam int MAG_BITS  = VEL_BITS + 1;
    localparam int CHAN_BITS = 2;
    localparam int MASK_BITS = 3;

    typedef enum logic
    {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        SIGN_NONE = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    typedef struct packed
    {
        logic set_en;
        logic tick_en;
        logic neg;
    } lane_cmd_t;

    typedef struct packed
    {
        logic pulse;
        logic dir;
    } lane_stat_t;

endpackage

>>> hdl/dspg_lane.sv
`timescale 1ns / 1ps

module dspg_lane
    import dspg_pkg::*;
#(
    parameter int PHASE_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lane_cmd_t             cmd,
    input  logic [PHASE_BITS-1:0] mag,
    output lane_stat_t            stat
);

    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] step_next;
    sign_t                 sign_reg;
    sign_t                 sign_next;
    logic [PHASE_BITS:0]   sum;
    sign_t                 new_sign;
    logic                  pulse;

    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        sign_next  = sign_reg;
        pulse      = 1'b0;
        sum        = {1'b0, phase_reg} + {1'b0, step_reg};
        new_sign   = cmd.neg ? SIGN_NEG : SIGN_POS;
        if (cmd.tick_en)
        begin
            phase_next = sum[PHASE_BITS-1:0];
            pulse      = sum[PHASE_BITS];
        end
        else if (cmd.set_en)
        begin
            // direction reversal restarts the phase
            if (sign_reg != SIGN_NONE && sign_reg != new_sign)
            begin
                phase_next = '0;
            end
            step_next = mag;
            sign_next = new_sign;
        end
        stat.pulse = pulse;
        stat.dir   = (sign_next == SIGN_NEG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            step_reg  <= '0;
            sign_reg  <= SIGN_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            sign_reg  <= sign_next;
        end
    end

endmodule

>>> hdl/dds_step_pulse_generator.sv
`timescale 1ns / 1ps
// channel  valid      stall      fields
// input    in_valid   in_stall   op, channel, velocity
// output   out_valid  out_stall  pulse_mask, direction_mask
//
// one word per cycle sustained while the result does not stall; each channel
// updates with its own phase adder; a word is registered at acceptance and its
// result is registered when the result register is free or drains
// reset clears all phases, increments and directions at once, no sweep
// a stalled result holds; the input register still takes a word while the
// result waits and stalls only when both registers are full and the result is stalled

module dds_step_pulse_generator
    import dspg_pkg::*;
#(
    parameter int CHANNELS   = 3,
    parameter int PHASE_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic [CHAN_BITS-1:0]       channel,
    input  logic signed [VEL_BITS-1:0] velocity,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [MASK_BITS-1:0]       pulse_mask,
    output logic [MASK_BITS-1:0]       direction_mask
);

`include "dds_step_pulse_generator_macros.svh"

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic                       op_reg;
    logic [CHAN_BITS-1:0]       channel_reg;
    logic signed [VEL_BITS-1:0] velocity_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [MASK_BITS-1:0]       pulse_reg;
    logic [MASK_BITS-1:0]       pulse_next;
    logic [MASK_BITS-1:0]       dir_reg;
    logic [MASK_BITS-1:0]       dir_next;
    logic                       advance;
    logic                       in_take;
    logic                       vel_neg;
    logic [MAG_BITS-1:0]        mag_full;
    logic [PHASE_BITS-1:0]      mag_sat;
    lane_cmd_t                  lane_cmd  [CHANNELS];
    lane_stat_t                 lane_stat [CHANNELS];

    // word moves into the result register when that register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign vel_neg  = velocity_reg[VEL_BITS-1];
    assign mag_full = vel_neg ? (MAG_BITS'(0) - {velocity_reg[VEL_BITS-1], velocity_reg})
                              : {1'b0, velocity_reg};

    generate
        if (PHASE_BITS >= MAG_BITS)
        begin : g_mag_wide
            assign mag_sat = PHASE_BITS'(mag_full);
        end
        else
        begin : g_mag_sat
            assign mag_sat = (|mag_full[MAG_BITS-1:PHASE_BITS]) ? '1
                                                                : mag_full[PHASE_BITS-1:0];
        end
    endgenerate

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++)
        begin : g_lane
            assign lane_cmd[c].set_en  = advance && (op_reg == OP_SET)
                                         && (32'(channel_reg) == c);
            assign lane_cmd[c].tick_en = advance && (op_reg == OP_TICK);
            assign lane_cmd[c].neg     = vel_neg;

            dspg_lane #(
                .PHASE_BITS (PHASE_BITS)
            ) u_lane (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (lane_cmd[c]),
                .mag   (mag_sat),
                .stat  (lane_stat[c])
            );
        end

        // only the first channels fit in the masks
        for (c = 0; c < MASK_BITS; c++)
        begin : g_mask
            if (c < CHANNELS)
            begin : g_used
                assign pulse_next[c] = lane_stat[c].pulse;
                assign dir_next[c]   = lane_stat[c].dir;
            end
            else
            begin : g_unused
                assign pulse_next[c] = 1'b0;
                assign dir_next[c]   = 1'b0;
            end
        end
    endgenerate

    always_comb
    begin
        in_valid_next = in_take || (in_valid_reg && !advance);
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg       <= op;
            channel_reg  <= channel;
            velocity_reg <= velocity;
        end
        if (advance)
        begin
            pulse_reg <= pulse_next;
            dir_reg   <= dir_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pulse_mask     = pulse_reg;
    assign direction_mask = dir_reg;

    `DSPG_ASSERT_NEXT(a_set_no_pulse, clk, rst_n, advance && (op_reg == OP_SET), pulse_mask == '0)
    `DSPG_ASSERT_NEXT(a_neg_dir0, clk, rst_n, advance && (op_reg == OP_SET) && (channel_reg == '0) && vel_neg, direction_mask[0])
    `DSPG_ASSERT_SAME(a_stall_full, clk, rst_n, in_stall, in_valid_reg && out_valid_reg && out_stall)

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dspg_pkg::*;

    localparam int CHANNELS    = 3;
    localparam int PHASE_BITS  = 16;
    localparam int RANDOM_WORDS = 750;
    localparam int CALM_TAIL   = 150;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [MAG_BITS-1:0] PHASE_MAX = MAG_BITS'((1 << PHASE_BITS) - 1);

    typedef struct packed
    {
        logic [MASK_BITS-1:0] pulse_mask;
        logic [MASK_BITS-1:0] direction_mask;
    } step_word_t;

    typedef struct
    {
        op_t                       op;
        logic [CHAN_BITS-1:0]      channel;
        logic signed [VEL_BITS-1:0] velocity;
        bit                        typed;
        step_word_t                result;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic                        op;
    logic [CHAN_BITS-1:0]        channel;
    logic signed [VEL_BITS-1:0]  velocity;
    logic                        out_valid;
    logic                        out_stall;
    logic [MASK_BITS-1:0]        pulse_mask;
    logic [MASK_BITS-1:0]        direction_mask;

    logic [PHASE_BITS-1:0] model_phase [CHANNELS];
    logic [PHASE_BITS-1:0] model_step [CHANNELS];
    sign_t                 model_sign [CHANNELS];

    step_word_t pending_step_words [$];
    stim_row_t  directed_rows [DIRECTED_ROWS];
    int         error_count;
    int         cycle_count;
    bit         idle_enabled;
    int         stall_left;

    dds_step_pulse_generator
    #(
        .CHANNELS   (CHANNELS),
        .PHASE_BITS (PHASE_BITS)
    )
    i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .channel        (channel),
        .velocity       (velocity),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pulse_mask     (pulse_mask),
        .direction_mask (direction_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void clear_step_model();
        for (int c = 0; c < CHANNELS; c++)
        begin
            model_phase[c] = '0;
            model_step[c]  = '0;
            model_sign[c]  = SIGN_NONE;
        end
    endfunction

    function automatic step_word_t compute_step_word(op_t o, logic [CHAN_BITS-1:0] ch,
                                                     logic signed [VEL_BITS-1:0] v);
        step_word_t           w;
        logic [MAG_BITS-1:0]  mag;
        logic [PHASE_BITS:0]  sum;
        sign_t                new_sign;
        w = '0;
        if (o == OP_SET)
        begin
            if (ch < CHANNELS)
            begin
                new_sign = v[VEL_BITS-1] ? SIGN_NEG : SIGN_POS;
                mag = v[VEL_BITS-1] ? (MAG_BITS'(1 << VEL_BITS) - {1'b0, v})
                                    : {1'b0, v};
                // a sign reversal restarts the phase, the first setting does not
                if (model_sign[ch] != SIGN_NONE && model_sign[ch] != new_sign)
                    model_phase[ch] = '0;
                if (mag > PHASE_MAX)
                    mag = PHASE_MAX;
                model_step[ch] = PHASE_BITS'(mag);
                model_sign[ch] = new_sign;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                sum = {1'b0, model_phase[c]} + model_step[c];
                if (c < MASK_BITS)
                    w.pulse_mask[c] = sum[PHASE_BITS];
                model_phase[c] = sum[PHASE_BITS-1:0];
            end
        end
        for (int c = 0; c < CHANNELS && c < MASK_BITS; c++)
            w.direction_mask[c] = (model_sign[c] == SIGN_NEG);
        return w;
    endfunction

    // entered and left at a falling edge
    task automatic send_word(op_t o, logic [CHAN_BITS-1:0] ch,
                             logic signed [VEL_BITS-1:0] v, bit typed, step_word_t typed_word);
        step_word_t predicted;
        if (idle_enabled && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        channel  <= ch;
        velocity <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = compute_step_word(o, ch, v);
        pending_step_words.push_back(typed ? typed_word : predicted);
        @(negedge clk);
    endtask

    function automatic logic signed [VEL_BITS-1:0] pick_velocity();
        logic signed [VEL_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: v = 16'sh8000;
                    1: v = 16'sh7fff;
                    2: v = 16'sh0000;
                    3: v = 16'shffff;
                    default: v = 16'sh0001;
                endcase
            end
            1: v = VEL_BITS'($signed($urandom_range(0, 600)) - 300);
            2: v = VEL_BITS'($signed($urandom_range(16384, 32767))
                               * ($urandom_range(0, 1) ? 1 : -1));
            default: v = VEL_BITS'($urandom);
        endcase
        return v;
    endfunction

    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (!idle_enabled)
            begin
                out_stall  <= 1'b0;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        step_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_step_words.size() == 0)
            begin
                $error("unexpected word: pulse_mask %0h direction_mask %0h",
                       pulse_mask, direction_mask);
                error_count++;
            end
            else
            begin
                want = pending_step_words.pop_front();
                if (pulse_mask !== want.pulse_mask)
                begin
                    $error("pulse_mask expected %0h actual %0h", want.pulse_mask, pulse_mask);
                    error_count++;
                end
                if (direction_mask !== want.direction_mask)
                begin
                    $error("direction_mask expected %0h actual %0h",
                           want.direction_mask, direction_mask);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        // typed rows: after reset, out-of-range channel, first settings at the extremes
        directed_rows[0]  = '{OP_TICK, 2'd0, 16'sh0000, 1'b1, '{3'b000, 3'b000}};
        directed_rows[1]  = '{OP_SET,  2'd3, -16'sd5,   1'b1, '{3'b000, 3'b000}};
        directed_rows[2]  = '{OP_SET,  2'd0, 16'sh8000, 1'b1, '{3'b000, 3'b001}};
        directed_rows[3]  = '{OP_SET,  2'd1, 16'sh7fff, 1'b1, '{3'b000, 3'b001}};
        directed_rows[4]  = '{OP_SET,  2'd2, 16'shffff, 1'b1, '{3'b000, 3'b101}};
        directed_rows[5]  = '{OP_TICK, 2'd0, 16'sh0000, 1'b0, '0};
        directed_rows[6]  = '{OP_TICK, 2'd1, 16'sh1234, 1'b0, '0};
        directed_rows[7]  = '{OP_TICK, 2'd2, 16'sh0000, 1'b0, '0};
        directed_rows[8]  = '{OP_SET,  2'd0, 16'sh0000, 1'b0, '0};
        directed_rows[9]  = '{OP_SET,  2'd0, 16'sh0000, 1'b0, '0};
        directed_rows[10] = '{OP_SET,  2'd2, 16'sh7fff, 1'b0, '0};
        directed_rows[11] = '{OP_TICK, 2'd0, 16'sh0000, 1'b0, '0};
        directed_rows[12] = '{OP_SET,  2'd1, 16'sh8000, 1'b0, '0};
        directed_rows[13] = '{OP_TICK, 2'd0, 16'sh0000, 1'b0, '0};
        directed_rows[14] = '{OP_TICK, 2'd0, 16'sh0000, 1'b0, '0};
        directed_rows[15] = '{OP_SET,  2'd3, 16'sh7fff, 1'b0, '0};
        directed_rows[16] = '{OP_SET,  2'd3, 16'sh8000, 1'b0, '0};
        directed_rows[17] = '{OP_SET,  2'd0, 16'shffff, 1'b0, '0};
        directed_rows[18] = '{OP_SET,  2'd0, 16'sh0001, 1'b0, '0};
        directed_rows[19] = '{OP_SET,  2'd2, 16'sh8000, 1'b0, '0};
        directed_rows[20] = '{OP_TICK, 2'd0, 16'sh0000, 1'b0, '0};
        directed_rows[21] = '{OP_TICK, 2'd0, 16'sh0000, 1'b0, '0};
        directed_rows[22] = '{OP_TICK, 2'd3, 16'shffff, 1'b0, '0};
        directed_rows[23] = '{OP_SET,  2'd1, 16'sh0000, 1'b0, '0};
        directed_rows[24] = '{OP_TICK, 2'd0, 16'sh0000, 1'b0, '0};

        error_count  = 0;
        cycle_count  = 0;
        idle_enabled = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        op       = OP_SET;
        channel  = '0;
        velocity = '0;
        clear_step_model();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_enabled = 1'b1;
        foreach (directed_rows[r])
            send_word(directed_rows[r].op, directed_rows[r].channel, directed_rows[r].velocity,
                      directed_rows[r].typed, directed_rows[r].result);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin : random_words
            op_t                        o;
            logic [CHAN_BITS-1:0]       ch;
            logic signed [VEL_BITS-1:0] v;
            // idle-free stretches, and none at all in the tail
            idle_enabled = (i < RANDOM_WORDS - CALM_TAIL) && ((i / 100) % 3 != 2);
            o  = ($urandom_range(0, 9) < 6) ? OP_TICK : OP_SET;
            ch = ($urandom_range(0, 9) == 0) ? 2'd3 : CHAN_BITS'($urandom_range(0, 2));
            v  = pick_velocity();
            send_word(o, ch, v, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_step_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
